// ===== rtl/core/bbc_pkg.sv =====
// Package for the bracket balance checker: word types, status codes, bracket constants.
package bbc_pkg;

    localparam logic [2:0] ST_PENDING   = 3'd0;
    localparam logic [2:0] ST_BALANCED  = 3'd1;
    localparam logic [2:0] ST_ROUND     = 3'd2;
    localparam logic [2:0] ST_SQUARE    = 3'd3;
    localparam logic [2:0] ST_CURLY     = 3'd4;
    localparam logic [2:0] ST_UNMATCHED = 3'd5;
    localparam logic [2:0] ST_UNCLOSED  = 3'd6;
    localparam logic [2:0] ST_OVERFLOW  = 3'd7;

    localparam logic [1:0] KIND_ROUND  = 2'd0;
    localparam logic [1:0] KIND_SQUARE = 2'd1;
    localparam logic [1:0] KIND_CURLY  = 2'd2;

    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;

    localparam logic [6:0] DEPTH_MAX_OUT = 7'd127;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last_symbol;
    } sym_word_t;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] nesting_depth;
        logic       text_done;
    } res_word_t;

    typedef struct packed {
        logic       is_open;
        logic       is_close;
        logic [1:0] kind;
        logic       last;
    } op_word_t;

endpackage

// ===== rtl/core/bracket_balance_checker.sv =====
// Bracket balance checker top level.
//
// sym channel: one byte of text per word with last_symbol on the final byte.
// res channel: one result word per byte: status, nesting depth after the
// byte and text_done on the final byte of a text.
// A word is taken when valid is high and stall is low.
// Throughput: one byte per cycle, sustained while res_stall is low; one stack push or
// pop per cycle with the top of stack in a register and the entry below it
// prefetched from the stack memory.
// A byte enters the front queue at the accepting edge and the stack engine's
// result register when the engine takes it from the queue; a receiver stall
// can hold it in the queue.
// Reset clears the stack pointer, the error latch, the front queue and the
// result valid; the stack memory is not cleared and needs no pass.
// Receiver stall: the result register holds, the two-entry front queue fills
// and sym_stall rises once it is full.
// After the final byte of a text the stack and error are cleared, so the next
// text may follow in the next cycle.
module bracket_balance_checker #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sym_valid,
    output logic               sym_stall,
    input  bbc_pkg::sym_word_t sym_word,
    output logic               res_valid,
    input  logic               res_stall,
    output bbc_pkg::res_word_t res_word
);
    import bbc_pkg::*;

    localparam int DEPTH_SAT = (STACK_DEPTH > 127) ? 127 : STACK_DEPTH;

    op_word_t front_word;
    op_word_t head_word;
    logic     q_full;
    logic     head_valid;
    logic     head_pop;

    assign sym_stall = q_full;

    bbc_front u_front (
        .sym_word (sym_word),
        .op_word  (front_word)
    );

    bbc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (sym_valid),
        .push_word  (front_word),
        .full       (q_full),
        .pop        (head_pop),
        .head_valid (head_valid),
        .head_word  (head_word)
    );

    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (head_valid),
        .op_word   (head_word),
        .op_pop    (head_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word)
    );

    a_balanced_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_word.status == ST_BALANCED) |-> res_word.nesting_depth == 7'd0)
        else $error("balanced result with nonzero depth");

    a_unclosed_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_word.status == ST_UNCLOSED) |-> res_word.nesting_depth != 7'd0)
        else $error("unclosed result with empty stack");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_word.status == ST_OVERFLOW) |->
            res_word.nesting_depth == 7'(DEPTH_SAT))
        else $error("overflow reported below full depth");

endmodule

// ===== rtl/core/bbc_front.sv =====
// Front end: classifies each incoming byte into a bracket operation word.
module bbc_front (
    input  bbc_pkg::sym_word_t sym_word,
    output bbc_pkg::op_word_t  op_word
);
    import bbc_pkg::*;

    always_comb
    begin
        op_word          = '0;
        op_word.last     = sym_word.last_symbol;
        case (sym_word.symbol)
            CH_OPEN_ROUND:
            begin
                op_word.is_open = 1'b1;
                op_word.kind    = KIND_ROUND;
            end
            CH_OPEN_SQUARE:
            begin
                op_word.is_open = 1'b1;
                op_word.kind    = KIND_SQUARE;
            end
            CH_OPEN_CURLY:
            begin
                op_word.is_open = 1'b1;
                op_word.kind    = KIND_CURLY;
            end
            CH_CLOSE_ROUND:
            begin
                op_word.is_close = 1'b1;
                op_word.kind     = KIND_ROUND;
            end
            CH_CLOSE_SQUARE:
            begin
                op_word.is_close = 1'b1;
                op_word.kind     = KIND_SQUARE;
            end
            CH_CLOSE_CURLY:
            begin
                op_word.is_close = 1'b1;
                op_word.kind     = KIND_CURLY;
            end
            default:
            begin
                op_word.is_open  = 1'b0;
                op_word.is_close = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/bbc_queue.sv =====
// Two-entry queue of operation words between the front end and the stack engine.
module bbc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bbc_pkg::op_word_t push_word,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output bbc_pkg::op_word_t head_word
);
    import bbc_pkg::*;

    op_word_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_word  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ===== rtl/core/bbc_back.sv =====
// Stack engine: bracket stack with registered top, error latch and result register.
module bbc_back #(
    parameter int STACK_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               op_valid,
    input  bbc_pkg::op_word_t  op_word,
    output logic               op_pop,
    output logic               res_valid,
    input  logic               res_stall,
    output bbc_pkg::res_word_t res_word
);
    import bbc_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int DW = (PW > 7) ? PW : 7;

    logic [1:0]    stack_mem [STACK_DEPTH];
    logic [1:0]    below_reg;
    logic [1:0]    top_reg;
    logic [1:0]    top_next;
    logic [PW-1:0] sp_reg;
    logic [PW-1:0] sp_next;
    logic [PW-1:0] sp_post;
    logic [2:0]    err_reg;
    logic [2:0]    err_next;
    logic          fire;
    logic          stack_we;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] sp_wide;
    logic          res_valid_reg;
    res_word_t     res_word_reg;
    res_word_t     res_word_next;

    assign fire      = op_valid && (!res_valid_reg || !res_stall);
    assign op_pop    = fire;
    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    always_comb
    begin
        err_next = err_reg;
        sp_post  = sp_reg;
        top_next = top_reg;
        stack_we = 1'b0;
        if (fire && (err_reg == ST_PENDING))
        begin
            if (op_word.is_open)
            begin
                if (sp_reg == PW'(STACK_DEPTH))
                begin
                    err_next = ST_OVERFLOW;
                end
                else
                begin
                    stack_we = 1'b1;
                    top_next = op_word.kind;
                    sp_post  = sp_reg + PW'(1);
                end
            end
            else if (op_word.is_close)
            begin
                if (sp_reg == '0)
                begin
                    err_next = ST_UNMATCHED;
                end
                else if (top_reg == op_word.kind)
                begin
                    top_next = below_reg;
                    sp_post  = sp_reg - PW'(1);
                end
                else
                begin
                    err_next = ST_ROUND + {1'b0, op_word.kind};
                end
            end
        end

        sp_wide = DW'(sp_post);
        res_word_next.nesting_depth = (sp_wide > DW'(DEPTH_MAX_OUT)) ?
                                      DEPTH_MAX_OUT : sp_wide[6:0];
        res_word_next.text_done = op_word.last;
        sp_next = sp_post;
        if (op_word.last)
        begin
            if (err_next != ST_PENDING)
            begin
                res_word_next.status = err_next;
            end
            else
            begin
                res_word_next.status = (sp_post == '0) ? ST_BALANCED : ST_UNCLOSED;
            end
            if (fire)
            begin
                sp_next  = '0;
                err_next = ST_PENDING;
            end
        end
        else
        begin
            res_word_next.status = err_next;
        end

        rd_addr = sp_next[AW-1:0] - AW'(2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            err_reg       <= ST_PENDING;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg  <= sp_next;
            err_reg <= err_next;
            if (fire)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (fire)
        begin
            res_word_reg <= res_word_next;
        end
    end

    // entry below the top is prefetched for the next pop
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[sp_reg[AW-1:0]] <= op_word.kind;
        end
        below_reg <= stack_mem[rd_addr];
    end

endmodule
